// ===== rtl/dke_pkg.sv =====
package dke_pkg;

    // Field widths of the channels
    localparam int KEY_W   = 8;
    localparam int EVENT_W = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    // Key codes; digits are the codes strictly between the two bounds
    localparam logic [KEY_W-1:0] KEY_BACKSPACE   = 8'd8;
    localparam logic [KEY_W-1:0] KEY_ENTER       = 8'd13;
    localparam logic [KEY_W-1:0] KEY_ESCAPE      = 8'd27;
    localparam logic [KEY_W-1:0] KEY_DIGIT_BELOW = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_DIGIT_ABOVE = 8'h3A;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_EDIT      = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ENTERED   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_CANCELLED = 2'd2;

    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 32'hFFFF_FFFF;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [EVENT_W-1:0] event_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        event_t event_res;
        value_t entry_value;
        count_t digit_count;
    } res_t;

endpackage

// ===== rtl/dke_key_if.sv =====
interface dke_key_if;
    logic          valid;
    logic          ready;
    dke_pkg::key_t key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

// ===== rtl/dke_res_if.sv =====
interface dke_res_if;
    logic            valid;
    logic            ready;
    dke_pkg::event_t event_res;
    dke_pkg::value_t entry_value;
    dke_pkg::count_t digit_count;

    modport source (output valid, output event_res, output entry_value,
                    output digit_count, input ready);
    modport sink   (input valid, input event_res, input entry_value,
                    input digit_count, output ready);
endinterface

// ===== rtl/decimal_key_entry_with_limit.sv =====
// Channel   Role   Fields                                    Transfer
// keys      sink   key[7:0]                                  valid & ready
// results   source event_res[1:0] entry_value[31:0]          valid & ready
//                  digit_count[3:0]
// cfg       write  cfg_wdata[31:0] -> max_value              cfg_we
//
// One item per cycle sustained while results drain; a taken item is held in
// the key register, then moves to the result register once that is free.
// The rate is set by the single state update (x*10+d and its compares) that
// feeds back on itself.
// Reset clears the held number, digit count, max_value (all ones) and both
// stage valids. A stalled result holds the result register; the key stage keeps
// taking items while it is empty or the result register is free or draining.
module decimal_key_entry_with_limit #(
    parameter int MAX_DIGITS = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    dke_key_if.sink           keys,
    dke_res_if.source         results,
    input  logic              cfg_we,
    input  dke_pkg::value_t   cfg_wdata
);

    // Key stage (input register)
    logic            key_vld_reg;
    dke_pkg::key_t   key_reg;

    // Result stage (output register)
    logic            out_vld_reg;
    dke_pkg::res_t   res_reg;

    dke_pkg::value_t max_value_reg;
    dke_pkg::res_t   res_next;
    logic            advance;

    // The held key moves on when the result register is empty or drains now.
    // The entry state is updated at that same edge, so state and results
    // always follow item order.
    assign advance    = key_vld_reg && (!out_vld_reg || results.ready);
    assign keys.ready = !key_vld_reg || advance;

    dke_entry #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_entry (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .key       (key_reg),
        .max_value (max_value_reg),
        .res       (res_next)
    );

    // Limit register; user must write it only while no item is in flight, unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= dke_pkg::MAX_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            max_value_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (keys.ready)
            begin
                key_vld_reg <= keys.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (keys.ready && keys.valid)
        begin
            key_reg <= keys.key;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.event_res   = res_reg.event_res;
    assign results.entry_value = res_reg.entry_value;
    assign results.digit_count = res_reg.digit_count;

endmodule

// ===== rtl/dke_entry.sv =====
// Entry state, digit history and the per-key update.
// Backspace pops the value held before the last digit instead of dividing.
module dke_entry #(
    parameter int MAX_DIGITS = 10,
    parameter int VALUE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  dke_pkg::key_t          key,
    input  dke_pkg::value_t        max_value,
    output dke_pkg::res_t          res
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int WIDE_W = VALUE_BITS + 4;

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] hist_reg [MAX_DIGITS];

    logic [WIDE_W-1:0]     value_wide;
    logic [WIDE_W-1:0]     append_wide;
    logic [WIDE_W-1:0]     max_lim;
    logic [CNT_W-1:0]      top_pos;
    logic                  is_digit;
    logic                  push;
    logic                  restart;
    dke_pkg::event_t       ev;

    assign is_digit = (key > dke_pkg::KEY_DIGIT_BELOW) && (key < dke_pkg::KEY_DIGIT_ABOVE);

    // value*10 + digit, wide enough to see an overflow of VALUE_BITS
    assign value_wide  = WIDE_W'(value_reg);
    assign append_wide = (value_wide << 3) + (value_wide << 1) + WIDE_W'(key[3:0]);
    assign max_lim     = WIDE_W'(max_value) & WIDE_W'({VALUE_BITS{1'b1}});
    assign top_pos     = count_reg - CNT_W'(1);

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        push       = 1'b0;
        restart    = 1'b0;
        ev         = dke_pkg::EV_EDIT;
        if (is_digit)
        begin
            if ((count_reg < CNT_W'(MAX_DIGITS)) && (append_wide <= max_lim))
            begin
                push       = 1'b1;
                value_next = append_wide[VALUE_BITS-1:0];
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (key == dke_pkg::KEY_BACKSPACE)
        begin
            if (count_reg != '0)
            begin
                value_next = hist_reg[top_pos[IDX_W-1:0]];
                count_next = top_pos;
            end
        end
        else if (key == dke_pkg::KEY_ENTER)
        begin
            if (count_reg != '0)
            begin
                ev      = dke_pkg::EV_ENTERED;
                restart = 1'b1;
            end
        end
        else if (key == dke_pkg::KEY_ESCAPE)
        begin
            ev      = dke_pkg::EV_CANCELLED;
            restart = 1'b1;
        end
        if (restart)
        begin
            value_next = '0;
            count_next = '0;
        end
    end

    // Enter and escape report the state held before the restart
    always_comb
    begin
        res.event_res   = ev;
        res.entry_value = restart ? dke_pkg::VALUE_W'(value_reg)
                                  : dke_pkg::VALUE_W'(value_next);
        res.digit_count = restart ? dke_pkg::COUNT_W'(count_reg)
                                  : dke_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    // History: entry i holds the value before digit i+1 was appended
    always_ff @(posedge clk)
    begin
        if (step && push)
        begin
            hist_reg[count_reg[IDX_W-1:0]] <= value_reg;
        end
    end

endmodule

// ===== tb/tb_decimal_key_entry_with_limit.sv =====
`timescale 1ns / 100ps

module tb_decimal_key_entry_with_limit;

    localparam int ENTRY_DIGITS = 10;
    localparam int ENTRY_BITS   = 32;
    localparam longint unsigned ENTRY_MASK = (64'd1 << ENTRY_BITS) - 64'd1;

    // Nothing accepted on either channel over a stretch this long ends the run.
    // Worst legal quiet stretch is the long receiver hold-off plus a long gap
    // on each side, so this leaves a wide margin.
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_OFF      = 300;
    localparam int KEYS_PER_LEG  = 116;
    localparam int LEGS          = 13;
    localparam int REPORT_MAX    = 10;

    // One row of the directed table: the key, and the result typed in by
    // hand where it is obvious; other rows take the predicted result.
    typedef struct packed {
        dke_pkg::key_t key;
        logic          typed;
        dke_pkg::res_t want;
    } key_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    dke_pkg::value_t cfg_wdata;

    dke_key_if keys ();
    dke_res_if results ();

    decimal_key_entry_with_limit #(
        .MAX_DIGITS (ENTRY_DIGITS),
        .VALUE_BITS (ENTRY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the entry: number built so far, digits held, and the limit.
    longint unsigned shadow_value;
    int              shadow_digits;
    longint unsigned limit_value;

    dke_pkg::res_t pending_results[$];
    key_row_t      key_table[$];

    int  errors;
    int  mismatches;
    int  counted_keys;
    int  quiet_cycles;
    bit  steady;        // no idling on either side while set
    bit  squeeze_req;   // asks the receiver for one long hold-off

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Next result of the entry for one key; updates the shadow state.
    function automatic dke_pkg::res_t next_entry_result(input dke_pkg::key_t k);
        dke_pkg::res_t r;
        longint unsigned digit;
        longint unsigned grown;
        r.event_res   = dke_pkg::EV_EDIT;
        if (k > dke_pkg::KEY_DIGIT_BELOW && k < dke_pkg::KEY_DIGIT_ABOVE) begin
            digit = 64'(k[3:0]);
            // must fit both the digit budget and the value width first
            if (shadow_digits < ENTRY_DIGITS &&
                shadow_value <= (ENTRY_MASK - digit) / 10) begin
                grown = shadow_value * 10 + digit;
                if (grown <= (limit_value & ENTRY_MASK)) begin
                    shadow_value  = grown;
                    shadow_digits = shadow_digits + 1;
                end
            end
        end else if (k == dke_pkg::KEY_BACKSPACE) begin
            if (shadow_digits > 0) begin
                shadow_value  = shadow_value / 10;
                shadow_digits = shadow_digits - 1;
            end
        end else if (k == dke_pkg::KEY_ENTER) begin
            // enter on an empty entry is just an edit event
            if (shadow_digits > 0)
                r.event_res = dke_pkg::EV_ENTERED;
        end else if (k == dke_pkg::KEY_ESCAPE) begin
            r.event_res = dke_pkg::EV_CANCELLED;
        end
        r.entry_value = dke_pkg::value_t'(shadow_value);
        r.digit_count = dke_pkg::count_t'(shadow_digits);
        // value and count are reported before the restart
        if (r.event_res != dke_pkg::EV_EDIT) begin
            shadow_value  = 0;
            shadow_digits = 0;
        end
        return r;
    endfunction

    task automatic add_row(input dke_pkg::key_t k, input logic typed,
                           input dke_pkg::event_t ev, input dke_pkg::value_t val,
                           input dke_pkg::count_t cnt);
        key_row_t row;
        row.key  = k;
        row.typed = typed;
        row.want.event_res   = ev;
        row.want.entry_value = val;
        row.want.digit_count = cnt;
        key_table.push_back(row);
    endtask

    // Offer one key, wait for it to be taken, queue its expected result.
    task automatic send_key(input dke_pkg::key_t k, input logic typed,
                            input dke_pkg::res_t want);
        int gap;
        dke_pkg::res_t predicted;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            keys.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        keys.valid <= 1'b1;
        keys.key   <= k;
        do
            @(posedge clk);
        while (!keys.ready);
        predicted = next_entry_result(k);
        pending_results.push_back(typed ? want : predicted);
        counted_keys++;
    endtask

    // Change the limit only with the block drained.
    task automatic write_limit(input dke_pkg::value_t v);
        keys.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // key and result registers are empty now; idle before touching the register
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        limit_value = 64'(v);
    endtask

    // One typed number: random digits, or a prefix of the limit itself so
    // the entry lands on and just past the boundary, or a run of leading
    // zeros. Sprinkled with backspaces and stray codes, closed by enter or
    // escape most of the time. Some calls are pure noise instead.
    task automatic type_entry();
        string lim;
        int mode;
        int len;
        int prefix;
        int zeros;
        int i;
        int r;
        dke_pkg::key_t d;
        lim  = $sformatf("%0d", limit_value);
        mode = $urandom_range(0, 99);
        if (mode < 12) begin
            repeat ($urandom_range(1, 4))
                send_key(dke_pkg::key_t'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            len    = $urandom_range(1, 11);
            prefix = (mode < 55) ? $urandom_range(0, lim.len()) : 0;
            zeros  = (mode >= 55 && mode < 65) ? $urandom_range(1, ENTRY_DIGITS) : 0;
            for (i = 0; i < len; i++) begin
                if (i < prefix)
                    d = lim[i];
                else if (i < zeros)
                    d = dke_pkg::key_t'(dke_pkg::KEY_DIGIT_BELOW + 8'd1);
                else
                    d = dke_pkg::key_t'(dke_pkg::KEY_DIGIT_BELOW + 8'd1
                                        + dke_pkg::key_t'($urandom_range(0, 9)));
                if ($urandom_range(0, 19) == 0)
                    send_key(dke_pkg::KEY_BACKSPACE, 1'b0, '0);
                if ($urandom_range(0, 29) == 0)
                    send_key(dke_pkg::key_t'($urandom_range(0, 255)), 1'b0, '0);
                send_key(d, 1'b0, '0);
            end
            r = $urandom_range(0, 9);
            if (r < 7)
                send_key(dke_pkg::KEY_ENTER, 1'b0, '0);
            else if (r < 9)
                send_key(dke_pkg::KEY_ESCAPE, 1'b0, '0);
        end
    endtask

    // Receiver: random ready with stalls, one long hold-off on request.
    int ready_hold;
    initial
    begin
        results.ready <= 1'b0;
        ready_hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (squeeze_req) begin
                // key side keeps offering; the block must fill and stall
                squeeze_req = 1'b0;
                results.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                ready_hold = 0;
            end else if (steady) begin
                results.ready <= 1'b1;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else if (results.ready) begin
                ready_hold = pick_gap();
                if (ready_hold != 0) begin
                    results.ready <= 1'b0;
                    ready_hold--;
                end
            end else begin
                results.ready <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end
        end
    end

    // Result checker: oldest expectation against each accepted result.
    always @(posedge clk)
    begin
        dke_pkg::res_t want;
        if (rst_n && results.valid && results.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: event %0d value %0d count %0d",
                             results.event_res, results.entry_value,
                             results.digit_count);
            end else begin
                want = pending_results.pop_front();
                if (results.event_res !== want.event_res ||
                    results.entry_value !== want.entry_value ||
                    results.digit_count !== want.digit_count) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d (ev/val/cnt)",
                                 want.event_res, want.entry_value, want.digit_count,
                                 results.event_res, results.entry_value,
                                 results.digit_count);
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((keys.valid && keys.ready) || (results.valid && results.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int leg;
        int i;
        string big;
        rst_n      <= 1'b0;
        keys.valid <= 1'b0;
        keys.key   <= '0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        errors       = 0;
        mismatches   = 0;
        counted_keys = 0;
        quiet_cycles = 0;
        steady       = 1'b0;
        squeeze_req  = 1'b0;
        shadow_value  = 0;
        shadow_digits = 0;
        limit_value   = 64'(dke_pkg::MAX_VALUE_RESET);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, limit still at its reset value (all ones).
        // leading zero counts as a digit, then backspace to empty
        add_row(dke_pkg::key_t'(dke_pkg::KEY_DIGIT_BELOW + 8'd1), 1'b1,
                dke_pkg::EV_EDIT, 32'd0, 4'd1);
        add_row(dke_pkg::KEY_BACKSPACE, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        // backspace, enter and escape on an empty entry
        add_row(dke_pkg::KEY_BACKSPACE, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_ENTER, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_ESCAPE, 1'b1, dke_pkg::EV_CANCELLED, 32'd0, 4'd0);
        // ignored codes: extremes and the two just outside the digit range
        add_row(8'h00, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(8'hFF, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_DIGIT_BELOW, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_DIGIT_ABOVE, 1'b1, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        // largest value with all ten digits
        big = "4294967295";
        for (i = 0; i < big.len(); i++)
            add_row(big[i], (i == big.len() - 1), dke_pkg::EV_EDIT, 32'hFFFF_FFFF,
                    dke_pkg::count_t'(ENTRY_DIGITS));
        // eleventh digit refused, then enter reports the full value
        add_row(dke_pkg::key_t'(dke_pkg::KEY_DIGIT_BELOW + 8'd2), 1'b1,
                dke_pkg::EV_EDIT, 32'hFFFF_FFFF, dke_pkg::count_t'(ENTRY_DIGITS));
        add_row(dke_pkg::KEY_ENTER, 1'b1, dke_pkg::EV_ENTERED, 32'hFFFF_FFFF,
                dke_pkg::count_t'(ENTRY_DIGITS));
        // stray code while holding a digit, then escape cancels it
        add_row(dke_pkg::key_t'(dke_pkg::KEY_DIGIT_BELOW + 8'd8), 1'b0,
                dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_DIGIT_BELOW, 1'b0, dke_pkg::EV_EDIT, 32'd0, 4'd0);
        add_row(dke_pkg::KEY_ESCAPE, 1'b1, dke_pkg::EV_CANCELLED, 32'd7, 4'd1);

        foreach (key_table[i])
            send_key(key_table[i].key, key_table[i].typed, key_table[i].want);

        // Random legs, each under its own limit. Leg 0 keeps the reset
        // limit and carries the long receiver hold-off.
        for (leg = 0; leg < LEGS; leg++)
        begin
            case (leg)
                0:  ;
                1:  write_limit(32'd0);
                2:  write_limit(32'd1);
                3:  write_limit(32'd9);
                4:  write_limit(32'd10);
                5:  write_limit(32'd99);
                6:  write_limit(32'd12345);
                7:  write_limit(32'd999999999);
                8:  write_limit(dke_pkg::value_t'($urandom));
                9:  write_limit(dke_pkg::value_t'($urandom_range(0, 100000)));
                10: write_limit(32'hFFFF_FFFE);
                11: write_limit(32'd1000000000);
                default: write_limit(32'hFFFF_FFFF);
            endcase
            steady = (leg % 4 == 2);
            if (leg == 0)
                squeeze_req = 1'b1;
            counted_keys = 0;
            while (counted_keys < KEYS_PER_LEG)
                type_entry();
        end

        keys.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let any stray extra result show up
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
